@@ hdl/assert_macros.svh @@
// Assertion macros shared by the histogram RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define BHM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge.
`define BHM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `BHM_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

@@ hdl/bhm_pkg.sv @@
// Types, codes and helpers for the binned histogram with moments.
// Used by bhm_div and binned_histogram_with_moments.
package bhm_pkg;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_READ    = 2'd1,
    ACT_SUMMARY = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_ORIGIN = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_BINS   = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SSTART,
    ST_SDIV,
    ST_SRD,
    ST_SWR,
    ST_RRD,
    ST_RDAT,
    ST_MSTART,
    ST_MDIV,
    ST_M2DIV,
    ST_MSQ,
    ST_VAR,
    ST_SQRT,
    ST_DONE
  } state_e;

  // Quotient bits produced for a sample and for a full 64-bit divide.
  localparam logic [6:0] DIV_STEPS_SAMPLE = 7'd34;
  localparam logic [6:0] DIV_STEPS_FULL   = 7'd64;

  typedef struct packed {
    logic        start;
    logic [6:0]  steps;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

  // One result item; the last member sits in the lowest bits.
  typedef struct packed {
    logic        no_samples;
    logic [31:0] nonzero_samples;
    logic [30:0] rms_value;
    logic [31:0] mean_value;
    logic [42:0] bin_edge;
    logic [31:0] bin_tally;
    logic        in_range;
    logic [9:0]  bin_index;
  } result_t;

  // Lower edge of a bin: origin plus index times width, wrapped to 43 bits.
  function automatic logic [42:0] edge_of(logic [12:0] idx, logic [31:0] org,
                                          logic [30:0] w);
    logic [43:0] prod;
    prod = 44'(idx) * 44'(w);
    return {{11{org[31]}}, org} + prod[42:0];
  endfunction

endpackage

@@ hdl/bhm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bhm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bhm_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bhm_pkg for the request and response structs.
module bhm_div import bhm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [63:0] acc_q, quot_q;
  logic [31:0] rem_q, den_q;
  logic [32:0] rem_sh;
  logic        ge;
  logic [31:0] rem_n;

  // One restoring step: shift in the next numerator bit and try a subtract.
  always_comb begin
    rem_sh = {rem_q, acc_q[63]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_n  = ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
  end

  // Control: busy while steps remain, done pulses after the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q  <= req_i.num;
      den_q  <= req_i.den;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      acc_q  <= {acc_q[62:0], 1'b0};
      rem_q  <= rem_n;
      quot_q <= {quot_q[62:0], ge};
    end
  end

  assign rsp_o = '{busy: busy_q, done: done_q, quot: quot_q, rem: rem_q};

endmodule

@@ hdl/binned_histogram_with_moments.sv @@
// Top level of the binned histogram with mean, rms and mode.
// Depends on bhm_pkg, bhm_ram, bhm_div and assert_macros.svh.
//
// Input items arrive on s_tvalid/s_tready with the action in s_tuser and
// the sample and bin select in s_tdata. Every item yields one result item on
// m_tvalid/m_tready. Registers are written through cfg_we_i/cfg_idx_i; the user
// must write them only while the block is idle, which the block does not enforce.
// The block works on one item at a time; s_tready is high only when idle.
// Steps per item, from accept to result ready:
//   add sample: the 34-step divider finds the bin, unless the sample lies
//     below bin zero; then a read and, on a hit, a write-back of the bin count;
//   read bin: the registered RAM read, then output staging;
//   summary: two 64-step divides on the shared divider and a
//     32-step square root, all skipped when there are no non-zero samples;
//   clear all: one RAM entry zeroed per cycle.
// After reset a clearing pass over all BIN_DEPTH entries runs before the first
// item is accepted; configuration writes are taken during it.
// A finished result waits in the output register while the receiver
// stalls; the next item is accepted meanwhile but its result waits.
`include "assert_macros.svh"

module binned_histogram_with_moments import bhm_pkg::*; #(
  parameter int BIN_DEPTH = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // sample_value[31:0], bin_select[41:32], zero pad
  input  logic [1:0]   s_tuser,   // action[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  // bin_index, in_range, bin_tally, bin_edge, mean_value, rms_value,
  // nonzero_samples, no_samples, zero pad
  output logic [183:0] m_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int AW = $clog2(BIN_DEPTH);
  localparam logic [12:0] DEPTH13 = 13'(BIN_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(BIN_DEPTH - 1);

  state_e state_q, state_d;

  logic [31:0] origin_q;
  logic [30:0] width_q;
  logic [10:0] bins_q;

  logic [31:0] samp_q;
  logic [9:0]  sel_q;
  logic        clr_item_q;

  logic [31:0]        stat_count_q;
  logic signed [63:0] stat_sum_q;
  logic [63:0]        stat_sq_q;
  logic [AW-1:0]      mode_bin_q;
  logic [31:0]        mode_tally_q;

  logic [AW-1:0] idx_q, clr_addr_q;
  logic          hit_q;
  logic [31:0]   am_q;
  logic [63:0]   sq_q, msq_q, x_q, root_q, bit_q;
  logic [4:0]    sq_cnt_q;
  result_t       res_q, out_q;
  logic          out_valid_q;

  logic          in_acc;
  action_e       in_act;
  logic [30:0]   weff;
  logic [12:0]   n_act;
  logic [34:0]   sdiff, snum;
  logic [31:0]   mag;
  logic [64:0]   sum_x, sq_x;
  logic          q_hit;
  logic [31:0]   tally_new;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;
  logic [64:0]   qq;
  logic [31:0]   mean_n, am_n;
  logic [63:0]   m2, var_n, rb, root_n, x_n;
  logic          sq_ge;
  logic          out_free;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  assign in_acc   = s_tvalid && s_tready;
  assign in_act   = action_e'(s_tuser);
  assign s_tready = (state_q == ST_IDLE);
  assign out_free = !out_valid_q || m_tready;

  // Effective width and number of active bins.
  assign weff  = (width_q == 31'd0) ? 31'd1 : width_q;
  assign n_act = (13'(bins_q) > DEPTH13) ? DEPTH13 : 13'(bins_q);

  // Sample numerator 2*(v-origin)+w; negative means below bin zero.
  always_comb begin
    sdiff = {{3{samp_q[31]}}, samp_q} - {{3{origin_q[31]}}, origin_q};
    snum  = {sdiff[33:0], 1'b0} + {4'b0, weff};
  end

  // Bin hit test on the divider quotient.
  assign q_hit = (div_rsp.quot[63:13] == '0) && (div_rsp.quot[12:0] < n_act);

  // Saturating moment sums.
  always_comb begin
    mag   = samp_q[31] ? (~samp_q + 32'd1) : samp_q;
    sum_x = {stat_sum_q[63], stat_sum_q} + {{33{samp_q[31]}}, samp_q};
    sq_x  = {1'b0, stat_sq_q} + {1'b0, sq_q};
  end

  // Square of the sample magnitude, registered.
  always_ff @(posedge clk_i) begin
    sq_q <= 64'(mag) * 64'(mag);
  end

  // Divider requests: sample binning, then mean and second moment.
  always_comb begin
    div_req.start = (state_q == ST_SSTART && !snum[34]) || (state_q == ST_MSTART) ||
                    (state_q == ST_MDIV && div_rsp.done);
    div_req.steps = DIV_STEPS_FULL;
    div_req.den   = stat_count_q;
    div_req.num   = stat_sq_q;
    if (state_q == ST_SSTART) begin
      div_req.steps = DIV_STEPS_SAMPLE;
      div_req.den   = {weff, 1'b0};
      div_req.num   = {snum[33:0], 30'b0};
    end else if (state_q == ST_MSTART) begin
      // The mean is divided as a magnitude; the sign is restored afterwards.
      div_req.num = stat_sum_q[63] ? 64'(-stat_sum_q) : 64'(stat_sum_q);
    end
  end

  bhm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Floor mean, clamped to 32 bits, and its magnitude.
  always_comb begin
    qq = {1'b0, div_rsp.quot} + 65'(stat_sum_q[63] && (div_rsp.rem != 32'd0));
    if (!stat_sum_q[63]) begin
      if (qq > 65'h7FFF_FFFF) begin
        mean_n = 32'h7FFF_FFFF;
      end else begin
        mean_n = qq[31:0];
      end
      am_n = mean_n;
    end else begin
      if (qq > 65'h8000_0000) begin
        am_n = 32'h8000_0000;
      end else begin
        am_n = qq[31:0];
      end
      mean_n = ~am_n + 32'd1;
    end
  end

  // Variance and one square root step.
  always_comb begin
    m2     = div_rsp.quot;
    var_n  = (m2 > msq_q) ? (m2 - msq_q) : 64'd0;
    rb     = root_q + bit_q;
    sq_ge  = x_q >= rb;
    x_n    = sq_ge ? (x_q - rb) : x_q;
    root_n = sq_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);
  end

  // Bin count RAM: clearing sweep and read-modify-write of one bin.
  always_comb begin
    tally_new = (&ram_rdata) ? ram_rdata : (ram_rdata + 32'd1);
    ram_we    = (state_q == ST_CLEAR) || (state_q == ST_SWR && hit_q);
    ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : idx_q;
    ram_wdata = (state_q == ST_CLEAR) ? 32'd0 : tally_new;
    ram_raddr = (state_q == ST_SRD) ? idx_q : AW'(sel_q);
  end

  bhm_ram #(
    .WIDTH (32),
    .DEPTH (BIN_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == LAST_ADDR) begin
          state_d = clr_item_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_act)
            ACT_ADD:     state_d = ST_SSTART;
            ACT_READ:    state_d = ST_RRD;
            ACT_SUMMARY: state_d = (stat_count_q == 32'd0) ? ST_DONE : ST_MSTART;
            default:     state_d = ST_CLEAR;
          endcase
        end
      end
      ST_SSTART: state_d = snum[34] ? ST_SRD : ST_SDIV;
      ST_SDIV:   if (div_rsp.done) state_d = ST_SRD;
      ST_SRD:    state_d = ST_SWR;
      ST_SWR:    state_d = ST_DONE;
      ST_RRD:    state_d = ST_RDAT;
      ST_RDAT:   state_d = ST_DONE;
      ST_MSTART: state_d = ST_MDIV;
      ST_MDIV:   if (div_rsp.done) state_d = ST_M2DIV;
      ST_M2DIV:  if (div_rsp.done) state_d = ST_MSQ;
      ST_MSQ:    state_d = ST_VAR;
      ST_VAR:    state_d = ST_SQRT;
      ST_SQRT:   if (sq_cnt_q == 5'd31) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control registers: state, configuration, statistics, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      origin_q     <= '0;
      width_q      <= 31'd65536;
      bins_q       <= 11'd1024;
      clr_addr_q   <= '0;
      clr_item_q   <= 1'b0;
      stat_count_q <= '0;
      stat_sum_q   <= '0;
      stat_sq_q    <= '0;
      mode_bin_q   <= '0;
      mode_tally_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_ORIGIN: origin_q <= cfg_wdata_i;
          REG_WIDTH:  width_q  <= cfg_wdata_i[30:0];
          REG_BINS:   bins_q   <= cfg_wdata_i[10:0];
          default:    ;
        endcase
      end

      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == LAST_ADDR) begin
          clr_addr_q <= '0;
        end
      end

      if (in_acc) begin
        clr_item_q <= (in_act == ACT_CLEAR);
        if (in_act == ACT_CLEAR) begin
          stat_count_q <= '0;
          stat_sum_q   <= '0;
          stat_sq_q    <= '0;
          mode_bin_q   <= '0;
          mode_tally_q <= '0;
        end
      end

      // Moments follow every non-zero sample.
      if (state_q == ST_SRD && samp_q != 32'd0) begin
        if (!(&stat_count_q)) begin
          stat_count_q <= stat_count_q + 32'd1;
        end
        if (sum_x[64] != sum_x[63]) begin
          stat_sum_q <= sum_x[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
          stat_sum_q <= sum_x[63:0];
        end
        stat_sq_q <= sq_x[64] ? {64{1'b1}} : sq_x[63:0];
      end

      // First bin to reach a strictly larger count becomes the mode.
      if (state_q == ST_SWR && hit_q && tally_new > mode_tally_q) begin
        mode_tally_q <= tally_new;
        mode_bin_q   <= idx_q;
      end

      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload, working registers and the result being built.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      samp_q <= s_tdata[31:0];
      sel_q  <= s_tdata[41:32];
      res_q  <= '0;
      if (in_act == ACT_SUMMARY) begin
        res_q.bin_index       <= 10'(mode_bin_q);
        res_q.in_range        <= 13'(mode_bin_q) < n_act;
        res_q.bin_tally       <= mode_tally_q;
        res_q.bin_edge        <= edge_of(13'(mode_bin_q), origin_q, weff);
        res_q.nonzero_samples <= stat_count_q;
        res_q.no_samples      <= (stat_count_q == 32'd0);
      end
    end

    case (state_q)
      ST_SSTART: hit_q <= 1'b0;
      ST_SDIV: begin
        if (div_rsp.done) begin
          hit_q <= q_hit;
          idx_q <= div_rsp.quot[AW-1:0];
        end
      end
      ST_SWR: begin
        res_q.nonzero_samples <= stat_count_q;
        if (hit_q) begin
          res_q.bin_index <= 10'(idx_q);
          res_q.in_range  <= 1'b1;
          res_q.bin_tally <= tally_new;
          res_q.bin_edge  <= edge_of(13'(idx_q), origin_q, weff);
        end
      end
      ST_RDAT: begin
        res_q.bin_index       <= sel_q;
        res_q.in_range        <= {3'b0, sel_q} < n_act;
        res_q.bin_tally       <= ({3'b0, sel_q} < DEPTH13) ? ram_rdata : 32'd0;
        res_q.bin_edge        <= edge_of({3'b0, sel_q}, origin_q, weff);
        res_q.nonzero_samples <= stat_count_q;
      end
      ST_MDIV: begin
        if (div_rsp.done) begin
          res_q.mean_value <= mean_n;
          am_q             <= am_n;
        end
      end
      ST_MSQ: msq_q <= 64'(am_q) * 64'(am_q);
      ST_VAR: begin
        x_q      <= var_n;
        root_q   <= '0;
        bit_q    <= 64'd1 << 62;
        sq_cnt_q <= '0;
      end
      ST_SQRT: begin
        x_q      <= x_n;
        root_q   <= root_n;
        bit_q    <= bit_q >> 2;
        sq_cnt_q <= sq_cnt_q + 5'd1;
        if (sq_cnt_q == 5'd31) begin
          res_q.rms_value <= (root_n[63:31] != '0) ? 31'h7FFF_FFFF : root_n[30:0];
        end
      end
      default: ;
    endcase

    if (state_q == ST_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {2'b0, out_q};

  // The RAM is written only by the clearing sweep and the bin write-back.
  `BHM_ASSERT(a_ram_we_state, clk_i, rst_ni,
              ram_we |-> (state_q == ST_SWR || state_q == ST_CLEAR),
              "bin RAM written outside sweep or write-back")
  // The shared divider is never restarted while it is working.
  `BHM_ASSERT(a_div_start_idle, clk_i, rst_ni, div_req.start |-> !div_rsp.busy,
              "divider started while busy")
  // A quotient only arrives while the sequencer waits for one.
  `BHM_ASSERT_NEVER(a_div_done_waited, clk_i, rst_ni,
                    div_rsp.done && state_q != ST_SDIV && state_q != ST_MDIV &&
                    state_q != ST_M2DIV,
                    "divider result arrived with nobody waiting")
  // The sample count only falls through a clear.
  `BHM_ASSERT(a_count_monotone, clk_i, rst_ni,
              (state_q != ST_CLEAR && !(in_acc && in_act == ACT_CLEAR)) |=>
              (stat_count_q >= $past(stat_count_q)),
              "sample count decreased without a clear")

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for binned_histogram_with_moments.
// Depends on bhm_pkg and the block's RTL; it uses no other files.
// A built-in predictor computes the expected result for every item accepted
// on the input stream, and each result item is checked against it in order.
module tb_top;
  import bhm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBINS_MAX = 1024;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    action_e     act;
    bit [31:0]   sample;
    bit [9:0]    sel;
  } hist_item_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid;
  logic         s_tready;
  logic [47:0]  s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [183:0] m_tdata;
  logic         cfg_we_i;
  logic [1:0]   cfg_idx_i;
  logic [31:0]  cfg_wdata_i;

  binned_histogram_with_moments dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Histogram state kept by the predictor.
  bit [31:0]          hist_count[NBINS_MAX];
  bit [31:0]          nz_count;
  longint             moment_sum;
  longint unsigned    moment_sq;
  bit [9:0]           peak_bin;
  bit [31:0]          peak_tally;
  logic signed [31:0] origin_q;
  bit [30:0]          width_q;
  bit [10:0]          nbins_q;

  hist_item_t pend_q[$];
  result_t    result_q[$];

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          stall_req;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned err_cnt;
  int unsigned item_cnt;
  int unsigned checked_cnt;
  int unsigned act_cnt[4];

  // Clock and a single reset at the start.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // Integer square root, one result bit at a time from the top.
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic bit [42:0] lower_edge(bit [9:0] idx);
    longint w;
    longint e;
    w = (width_q == 0) ? 1 : longint'(width_q);
    e = longint'(origin_q) + longint'(idx) * w;
    return e[42:0];
  endfunction

  // Applies one item to the histogram state and returns the result it causes.
  function automatic result_t histogram_step(hist_item_t it);
    result_t r;
    longint  v;
    longint  w;
    longint  idx;
    longint  mean;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned m2;
    longint unsigned msq;
    longint unsigned var_q;
    longint unsigned rms;
    int unsigned n;
    r = '0;
    n = (nbins_q < NBINS_MAX) ? nbins_q : NBINS_MAX;
    case (it.act)
      ACT_ADD: begin
        v = longint'($signed(it.sample));
        w = (width_q == 0) ? 1 : longint'(width_q);
        idx = floor_quot(2 * (v - longint'(origin_q)) + w, 2 * w);
        // Zero samples are binned but leave the moments alone.
        if (v != 0) begin
          mag = (v < 0) ? -v : v;
          sq = mag * mag;
          if (nz_count != 32'hFFFF_FFFF) nz_count++;
          if (v > 0 && moment_sum > 64'sh7FFF_FFFF_FFFF_FFFF - v)
            moment_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
          else if (v < 0 && moment_sum < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - v)
            moment_sum = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
          else
            moment_sum += v;
          if (moment_sq > 64'hFFFF_FFFF_FFFF_FFFF - sq) moment_sq = '1;
          else moment_sq += sq;
        end
        if (idx >= 0 && idx < n) begin
          if (hist_count[idx] != 32'hFFFF_FFFF) hist_count[idx]++;
          if (hist_count[idx] > peak_tally) begin
            peak_tally = hist_count[idx];
            peak_bin = idx[9:0];
          end
          r.bin_index = idx[9:0];
          r.in_range = 1'b1;
          r.bin_tally = hist_count[idx];
          r.bin_edge = lower_edge(idx[9:0]);
        end
      end
      ACT_READ: begin
        r.bin_index = it.sel;
        r.in_range = (it.sel < n);
        r.bin_tally = hist_count[it.sel];
        r.bin_edge = lower_edge(it.sel);
      end
      ACT_SUMMARY: begin
        r.bin_index = peak_bin;
        r.in_range = (peak_bin < n);
        r.bin_tally = peak_tally;
        r.bin_edge = lower_edge(peak_bin);
        if (nz_count == 0) begin
          r.no_samples = 1'b1;
        end else begin
          mean = floor_quot(moment_sum, longint'(nz_count));
          if (mean > 64'sh7FFF_FFFF) mean = 64'sh7FFF_FFFF;
          if (mean < -64'sh8000_0000) mean = -64'sh8000_0000;
          m2 = moment_sq / longint'(nz_count);
          mag = (mean < 0) ? -mean : mean;
          msq = mag * mag;
          var_q = (m2 > msq) ? m2 - msq : 0;
          rms = int_sqrt(var_q);
          if (rms > 64'h7FFF_FFFF) rms = 64'h7FFF_FFFF;
          r.mean_value = mean[31:0];
          r.rms_value = rms[30:0];
        end
      end
      default: begin
        foreach (hist_count[i]) hist_count[i] = '0;
        nz_count = '0;
        moment_sum = 0;
        moment_sq = 0;
        peak_bin = '0;
        peak_tally = '0;
      end
    endcase
    r.nonzero_samples = nz_count;
    return r;
  endfunction

  // Input driver: offers queued items, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    hist_item_t nxt;
    bit         held;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
    end else begin
      held = s_tvalid;
      if (s_tvalid && s_tready) begin
        nxt.act = action_e'(s_tuser);
        nxt.sample = s_tdata[31:0];
        nxt.sel = s_tdata[41:32];
        result_q.push_back(histogram_step(nxt));
        item_cnt++;
        act_cnt[s_tuser]++;
        held = 1'b0;
      end
      if (!held) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          nxt = pend_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= nxt.act;
          s_tdata <= {6'b0, nxt.sel, nxt.sample};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[181:0]);
        if (result_q.size() == 0) begin
          $error("result item with no expectation pending");
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          checked_cnt++;
          if (got.bin_index !== want.bin_index) begin
            $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
            err_cnt++;
          end
          if (got.in_range !== want.in_range) begin
            $error("in_range: expected %0d, got %0d", want.in_range, got.in_range);
            err_cnt++;
          end
          if (got.bin_tally !== want.bin_tally) begin
            $error("bin_tally: expected %0d, got %0d", want.bin_tally, got.bin_tally);
            err_cnt++;
          end
          if (got.bin_edge !== want.bin_edge) begin
            $error("bin_edge: expected %h, got %h", want.bin_edge, got.bin_edge);
            err_cnt++;
          end
          if (got.mean_value !== want.mean_value) begin
            $error("mean_value: expected %h, got %h", want.mean_value, got.mean_value);
            err_cnt++;
          end
          if (got.rms_value !== want.rms_value) begin
            $error("rms_value: expected %h, got %h", want.rms_value, got.rms_value);
            err_cnt++;
          end
          if (got.nonzero_samples !== want.nonzero_samples) begin
            $error("nonzero_samples: expected %0d, got %0d", want.nonzero_samples,
                   got.nonzero_samples);
            err_cnt++;
          end
          if (got.no_samples !== want.no_samples) begin
            $error("no_samples: expected %0d, got %0d", want.no_samples, got.no_samples);
            err_cnt++;
          end
        end
      end
      // A requested long hold-off takes priority over random stalls.
      if (stall_req) begin
        stall_req = 1'b0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_e idx, bit [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ORIGIN: origin_q = val;
      REG_WIDTH:  width_q = val[30:0];
      default:    nbins_q = val[10:0];
    endcase
  endtask

  task automatic set_binning(bit [31:0] org, bit [31:0] w, bit [31:0] n);
    write_reg(REG_ORIGIN, org);
    write_reg(REG_WIDTH, w);
    write_reg(REG_BINS, n);
  endtask

  task automatic queue_item(action_e act, bit [31:0] sample, bit [9:0] sel);
    hist_item_t it;
    it.act = act;
    it.sample = sample;
    it.sel = sel;
    pend_q.push_back(it);
  endtask

  // Waits until every queued item has been sent and answered.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || result_q.size() != 0 || s_tvalid);
    repeat (10) @(posedge clk_i);
  endtask

  // Sample that mostly lands near the active bins under the current setting.
  function automatic bit [31:0] pick_sample();
    longint w;
    longint t;
    int unsigned n;
    n = (nbins_q < NBINS_MAX) ? nbins_q : NBINS_MAX;
    w = (width_q == 0) ? 1 : longint'(width_q);
    case ($urandom_range(9))
      0: return 32'h0;
      1: return ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2, 3: return $urandom;
      default: begin
        t = longint'(origin_q) + longint'($urandom_range(n)) * w
            + longint'($urandom_range(w[31:0] - 1, 0)) - w / 2;
        if (t > 64'sh7FFF_FFFF) t = 64'sh7FFF_FFFF;
        if (t < -64'sh8000_0000) t = -64'sh8000_0000;
        return t[31:0];
      end
    endcase
  endfunction

  task automatic queue_random(int unsigned count);
    int unsigned k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 70) queue_item(ACT_ADD, pick_sample(), 10'($urandom));
      else if (k < 86) queue_item(ACT_READ, $urandom, 10'($urandom));
      else if (k < 98) queue_item(ACT_SUMMARY, $urandom, 10'($urandom));
      else queue_item(ACT_CLEAR, $urandom, 10'($urandom));
    end
  endtask

  // Stimulus sequence and end of run.
  initial begin
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ORIGIN;
    cfg_wdata_i = '0;
    snd_idle_pct = 15;
    rcv_idle_pct = 84;
    stall_req = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    err_cnt = 0;
    item_cnt = 0;
    checked_cnt = 0;
    foreach (act_cnt[i]) act_cnt[i] = 0;
    foreach (hist_count[i]) hist_count[i] = '0;
    nz_count = '0;
    moment_sum = 0;
    moment_sq = 0;
    peak_bin = '0;
    peak_tally = '0;
    origin_q = 0;
    width_q = 31'd65536;
    nbins_q = 11'd1024;
    @(posedge rst_ni);

    // Directed part at width 65536, origin zero, all bins active.
    set_binning(32'h0, 32'h0001_0000, 32'd1024);
    queue_item(ACT_READ, 32'h0, 10'd0);
    queue_item(ACT_SUMMARY, 32'h0, 10'd0);
    queue_item(ACT_ADD, 32'h0, 10'd0);
    queue_item(ACT_ADD, 32'h0000_8000, 10'd0);
    queue_item(ACT_ADD, 32'h0000_7FFF, 10'd0);
    queue_item(ACT_ADD, 32'hFFFF_8000, 10'd0);
    queue_item(ACT_ADD, 32'hFFFF_7FFF, 10'd0);
    queue_item(ACT_ADD, 32'h03FF_0000, 10'd0);
    queue_item(ACT_ADD, 32'h0400_0000, 10'd0);
    queue_item(ACT_ADD, 32'h7FFF_FFFF, 10'd0);
    queue_item(ACT_SUMMARY, 32'h0, 10'd0);
    // Four full-scale negatives saturate the sum of squares.
    repeat (4) queue_item(ACT_ADD, 32'h8000_0000, 10'd0);
    queue_item(ACT_READ, 32'h0, 10'd1023);
    queue_item(ACT_READ, 32'h0, 10'd1);
    queue_item(ACT_SUMMARY, 32'h0, 10'd0);
    queue_item(ACT_CLEAR, 32'hFFFF_FFFF, 10'h3FF);
    queue_item(ACT_SUMMARY, 32'h0, 10'd0);
    queue_item(ACT_READ, 32'h0, 10'd1);
    queue_random(430);
    wait_drained();

    // Widest bins, lowest origin, one active bin; receiver mostly ready.
    set_binning(32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
    snd_idle_pct = 84;
    rcv_idle_pct = 15;
    queue_item(ACT_READ, 32'h0, 10'd1023);
    queue_random(430);
    wait_drained();

    // Narrow bins, negative origin, odd bin count; no idling plus a long hold.
    set_binning(32'hFFFB_0000, 32'd3, 32'd37);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    queue_random(150);
    wait_drained();
    set_binning(32'h7FFF_FFFF, 32'h0000_4000, 32'd1024);
    stall_req = 1'b1;
    queue_random(320);
    wait_drained();
    repeat (50) @(posedge clk_i);

    $display("tb_top: %0d items sent, %0d results checked", item_cnt, checked_cnt);
    $display("tb_top: adds %0d, reads %0d, summaries %0d, clears %0d over 4 bin settings",
             act_cnt[ACT_ADD], act_cnt[ACT_READ], act_cnt[ACT_SUMMARY], act_cnt[ACT_CLEAR]);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/bhm_pkg.sv
hdl/bhm_ram.sv
hdl/bhm_div.sv
hdl/binned_histogram_with_moments.sv
tb/sv/tb_top.sv
